[rtl/core/msie_pkg.sv]
// Package with opcode, function and type definitions for the integer subset executor.
package msie_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0a;
   localparam logic [5:0] OP_SLTIU   = 6'h0b;
   localparam logic [5:0] OP_ANDI    = 6'h0c;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2b;

   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2a;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_NOR, ALU_SLT, ALU_SLTU,
      ALU_ANDI, ALU_ORI, ALU_LUI, ALU_LINK, ALU_NONE
   } alu_op_type;

   typedef enum logic [2:0] {
      NXT_SEQ, NXT_JR, NXT_JUMP, NXT_BEQ, NXT_BNE, NXT_HOLD
   } next_sel_type;

   // Decoded instruction handed from the front part to the back part.
   typedef struct packed {
      logic [31:0]  word;
      logic         fault;
      alu_op_type   alu_op;
      next_sel_type next_sel;
      logic         use_imm;
      logic         reg_write;
      logic [4:0]   dest;
      logic         is_load;
      logic         is_store;
      logic [2:0]   nbytes;
   } decoded_type;

   typedef enum logic [1:0] {
      ST_CLEAR, ST_EXEC, ST_WAIT
   } state_type;

endpackage

[rtl/core/msie_decode.sv]
// Front part: accepts instruction transactions, classifies them and queues them.
module msie_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_instr_word,
   output logic                  dec_valid,
   input  logic                  dec_ready,
   output msie_pkg::decoded_type dec_item
);

   msie_pkg::decoded_type d;
   msie_pkg::decoded_type q_ff [2];
   msie_pkg::decoded_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [5:0] op, fn;

   assign op = req_instr_word[31:26];
   assign fn = req_instr_word[5:0];

   always_comb begin
      d = '0;
      d.word     = req_instr_word;
      d.alu_op   = msie_pkg::ALU_NONE;
      d.next_sel = msie_pkg::NXT_SEQ;
      d.dest     = req_instr_word[20:16];
      case (op)
         msie_pkg::OP_SPECIAL: begin
            d.dest = req_instr_word[15:11];
            d.reg_write = 1'b1;
            case (fn)
               msie_pkg::FN_JR: begin
                  d.reg_write = 1'b0;
                  d.next_sel = msie_pkg::NXT_JR;
               end
               msie_pkg::FN_ADD, msie_pkg::FN_ADDU: d.alu_op = msie_pkg::ALU_ADD;
               msie_pkg::FN_SUB, msie_pkg::FN_SUBU: d.alu_op = msie_pkg::ALU_SUB;
               msie_pkg::FN_AND:  d.alu_op = msie_pkg::ALU_AND;
               msie_pkg::FN_OR:   d.alu_op = msie_pkg::ALU_OR;
               msie_pkg::FN_NOR:  d.alu_op = msie_pkg::ALU_NOR;
               msie_pkg::FN_SLT:  d.alu_op = msie_pkg::ALU_SLT;
               msie_pkg::FN_SLTU: d.alu_op = msie_pkg::ALU_SLTU;
               default: begin
                  d.fault = 1'b1;
                  d.reg_write = 1'b0;
               end
            endcase
         end
         msie_pkg::OP_J: d.next_sel = msie_pkg::NXT_JUMP;
         msie_pkg::OP_JAL: begin
            d.next_sel = msie_pkg::NXT_JUMP;
            d.reg_write = 1'b1;
            d.dest = 5'd31;
            d.alu_op = msie_pkg::ALU_LINK;
         end
         msie_pkg::OP_BEQ: d.next_sel = msie_pkg::NXT_BEQ;
         msie_pkg::OP_BNE: d.next_sel = msie_pkg::NXT_BNE;
         msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: begin
            d.reg_write = 1'b1; d.use_imm = 1'b1; d.alu_op = msie_pkg::ALU_ADD;
         end
         msie_pkg::OP_SLTI: begin
            d.reg_write = 1'b1; d.use_imm = 1'b1; d.alu_op = msie_pkg::ALU_SLT;
         end
         msie_pkg::OP_SLTIU: begin
            d.reg_write = 1'b1; d.use_imm = 1'b1; d.alu_op = msie_pkg::ALU_SLTU;
         end
         msie_pkg::OP_ANDI: begin
            d.reg_write = 1'b1; d.alu_op = msie_pkg::ALU_ANDI;
         end
         msie_pkg::OP_ORI: begin
            d.reg_write = 1'b1; d.alu_op = msie_pkg::ALU_ORI;
         end
         msie_pkg::OP_LUI: begin
            d.reg_write = 1'b1; d.alu_op = msie_pkg::ALU_LUI;
         end
         msie_pkg::OP_LW: begin
            d.reg_write = 1'b1; d.is_load = 1'b1; d.nbytes = 3'd4;
         end
         msie_pkg::OP_LBU: begin
            d.reg_write = 1'b1; d.is_load = 1'b1; d.nbytes = 3'd1;
         end
         msie_pkg::OP_LHU: begin
            d.reg_write = 1'b1; d.is_load = 1'b1; d.nbytes = 3'd2;
         end
         msie_pkg::OP_SB: begin
            d.is_store = 1'b1; d.nbytes = 3'd1;
         end
         msie_pkg::OP_SH: begin
            d.is_store = 1'b1; d.nbytes = 3'd2;
         end
         msie_pkg::OP_SW: begin
            d.is_store = 1'b1; d.nbytes = 3'd4;
         end
         default: d.fault = 1'b1;
      endcase
      if (d.fault) d.next_sel = msie_pkg::NXT_HOLD;
      if (d.dest == 5'd0) d.reg_write = 1'b0;
   end

   // Two-entry queue.
   assign req_ready = (cnt_ff != 2'd2);
   assign dec_valid = (cnt_ff != 2'd0);
   assign dec_item  = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      q_in   = d;
      if (req_valid && req_ready) begin
         wr_in = ~wr_ff;
         cnt_in = cnt_in + 2'd1;
      end
      if (dec_valid && dec_ready) begin
         rd_in = ~rd_ff;
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (req_valid && req_ready) q_ff[wr_ff] <= q_in;
   end

endmodule

[rtl/core/msie_execute.sv]
// Back part: register file, data memory, program counter and result register.
module msie_execute #(
   parameter int MEM_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           start_address,
   input  logic                  dec_valid,
   output logic                  dec_ready,
   input  msie_pkg::decoded_type dec_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_exec_address,
   output logic [31:0]           rsp_next_address,
   output logic                  rsp_fault,
   output logic                  rsp_reg_written,
   output logic [4:0]            rsp_reg_index,
   output logic [31:0]           rsp_reg_value,
   output logic                  rsp_mem_written,
   output logic [11:0]           rsp_mem_address
);

   localparam int AW = $clog2(MEM_BYTES);

   // Memory is held as four byte banks indexed by address bits above the low two,
   // so that a word access reaches four consecutive bytes together.
   localparam int RW = AW - 2;
   localparam int ROWS = MEM_BYTES / 4;

   msie_pkg::state_type state_ff, state_in;
   logic [RW:0]  clr_ff, clr_in;
   logic [31:0]  pc_ff, pc_in;
   logic [31:0]  rf_ff [32];
   logic [7:0]   bank0 [ROWS];
   logic [7:0]   bank1 [ROWS];
   logic [7:0]   bank2 [ROWS];
   logic [7:0]   bank3 [ROWS];

   msie_pkg::decoded_type it_ff;
   logic [31:0] a_ff, b_ff, ea_ff;

   logic        ov_ff;
   logic [31:0] o_exec_ff, o_next_ff, o_val_ff;
   logic        o_fault_ff, o_rw_ff, o_mw_ff;
   logic [4:0]  o_idx_ff;
   logic [11:0] o_maddr_ff;

   logic [31:0] a_c, b_c, simm_c, ea_c;
   logic [AW-1:0] byte_addr [4];
   logic [RW-1:0] row_rd [4];
   logic [1:0]  bank_of [4];
   logic [7:0]  bytes_c [4];
   logic [31:0] opb, alu_v, load_v, wval, nxt, pc4;
   logic        take, fire, out_free, store_en;
   logic [7:0]  wb [4];
   logic        we [4];
   logic [RW-1:0] wrow [4];

   assign a_c = rf_ff[dec_item.word[25:21]];
   assign b_c = rf_ff[dec_item.word[20:16]];
   assign simm_c = {{16{dec_item.word[15]}}, dec_item.word[15:0]};
   assign ea_c = a_c + simm_c;
   assign pc_in = nxt;

   assign out_free = !ov_ff || rsp_ready;
   // Read stage takes an item when the execute stage is free this cycle.
   assign take = dec_valid && (state_ff == msie_pkg::ST_EXEC);
   assign dec_ready = take;
   assign fire = (state_ff == msie_pkg::ST_WAIT) && out_free;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         msie_pkg::ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (RW+1)'(ROWS - 1)) state_in = msie_pkg::ST_EXEC;
         end
         msie_pkg::ST_EXEC: if (take) state_in = msie_pkg::ST_WAIT;
         msie_pkg::ST_WAIT: if (out_free) state_in = msie_pkg::ST_EXEC;
         default: state_in = msie_pkg::ST_EXEC;
      endcase
   end

   // Byte addresses of the four potential access bytes, each wrapped alone.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         byte_addr[i] = AW'(ea_c + 32'(i));
         row_rd[i] = byte_addr[i][AW-1:2];
         bank_of[i] = byte_addr[i][1:0];
      end
   end

   // Each bank is read at the row that the byte landing in it needs.
   logic [RW-1:0] brow [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         brow[k] = row_rd[0];
         for (int i = 0; i < 4; i++)
            if (bank_of[i] == 2'(k)) brow[k] = row_rd[i];
      end
   end

   // The read data is held until the item that asked for it has executed.
   logic [7:0] bq_ff [4];
   always_ff @(posedge clock) begin
      if (take) begin
         bq_ff[0] <= bank0[brow[0]];
         bq_ff[1] <= bank1[brow[1]];
         bq_ff[2] <= bank2[brow[2]];
         bq_ff[3] <= bank3[brow[3]];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++)
         bytes_c[i] = bq_ff[ea_ff[1:0] + 2'(i)];
      case (it_ff.nbytes)
         3'd1:    load_v = {24'd0, bytes_c[0]};
         3'd2:    load_v = {16'd0, bytes_c[0], bytes_c[1]};
         default: load_v = {bytes_c[0], bytes_c[1], bytes_c[2], bytes_c[3]};
      endcase
   end

   always_comb begin
      pc4 = pc_ff + 32'd4;
      opb = it_ff.use_imm ? {{16{it_ff.word[15]}}, it_ff.word[15:0]} : b_ff;
      case (it_ff.alu_op)
         msie_pkg::ALU_ADD:  alu_v = a_ff + opb;
         msie_pkg::ALU_SUB:  alu_v = a_ff - opb;
         msie_pkg::ALU_AND:  alu_v = a_ff & opb;
         msie_pkg::ALU_OR:   alu_v = a_ff | opb;
         msie_pkg::ALU_NOR:  alu_v = ~(a_ff | opb);
         msie_pkg::ALU_SLT:  alu_v = {31'd0, $signed(a_ff) < $signed(opb)};
         msie_pkg::ALU_SLTU: alu_v = {31'd0, a_ff < opb};
         msie_pkg::ALU_ANDI: alu_v = a_ff & {16'd0, it_ff.word[15:0]};
         msie_pkg::ALU_ORI:  alu_v = a_ff | {16'd0, it_ff.word[15:0]};
         msie_pkg::ALU_LUI:  alu_v = {it_ff.word[15:0], 16'd0};
         msie_pkg::ALU_LINK: alu_v = pc4;
         default:            alu_v = 32'd0;
      endcase
      wval = it_ff.is_load ? load_v : alu_v;
      case (it_ff.next_sel)
         msie_pkg::NXT_JR:   nxt = a_ff;
         msie_pkg::NXT_JUMP: nxt = {pc4[31:28], it_ff.word[25:0], 2'b00};
         msie_pkg::NXT_BEQ:  nxt = (a_ff == b_ff) ?
            pc4 + {{14{it_ff.word[15]}}, it_ff.word[15:0], 2'b00} : pc4;
         msie_pkg::NXT_BNE:  nxt = (a_ff != b_ff) ?
            pc4 + {{14{it_ff.word[15]}}, it_ff.word[15:0], 2'b00} : pc4;
         msie_pkg::NXT_HOLD: nxt = pc_ff;
         default:            nxt = pc4;
      endcase
   end

   // Store byte lanes: byte i of the access goes to bank of its wrapped address.
   assign store_en = fire && it_ff.is_store;
   always_comb begin
      logic [AW-1:0] ba;
      logic [7:0] sb;
      for (int k = 0; k < 4; k++) begin
         we[k] = 1'b0;
         wb[k] = 8'd0;
         wrow[k] = clr_ff[RW-1:0];
      end
      if (state_ff == msie_pkg::ST_CLEAR) begin
         for (int k = 0; k < 4; k++) we[k] = 1'b1;
      end else begin
         for (int i = 0; i < 4; i++) begin
            ba = AW'(ea_ff + 32'(i));
            case (it_ff.nbytes)
               3'd1:    sb = b_ff[7:0];
               3'd2:    sb = (i == 0) ? b_ff[15:8] : b_ff[7:0];
               default: sb = b_ff[8*(3-i) +: 8];
            endcase
            if (store_en && (3'(i) < it_ff.nbytes)) begin
               we[ba[1:0]] = 1'b1;
               wb[ba[1:0]] = sb;
               wrow[ba[1:0]] = ba[AW-1:2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we[0]) bank0[wrow[0]] <= wb[0];
      if (we[1]) bank1[wrow[1]] <= wb[1];
      if (we[2]) bank2[wrow[2]] <= wb[2];
      if (we[3]) bank3[wrow[3]] <= wb[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msie_pkg::ST_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= start_address;
         ov_ff    <= 1'b0;
         for (int r = 0; r < 32; r++) rf_ff[r] <= 32'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (ov_ff && rsp_ready) ov_ff <= 1'b0;
         if (fire) begin
            ov_ff <= 1'b1;
            pc_ff <= pc_in;
            if (it_ff.reg_write) rf_ff[it_ff.dest] <= wval;
         end
      end
      if (take) begin
         it_ff <= dec_item;
         a_ff  <= a_c;
         b_ff  <= b_c;
         ea_ff <= ea_c;
      end
      if (fire) begin
         o_exec_ff  <= pc_ff;
         o_next_ff  <= nxt;
         o_fault_ff <= it_ff.fault;
         o_rw_ff    <= it_ff.reg_write;
         o_idx_ff   <= it_ff.reg_write ? it_ff.dest : 5'd0;
         o_val_ff   <= it_ff.reg_write ? wval : 32'd0;
         o_mw_ff    <= it_ff.is_store;
         o_maddr_ff <= it_ff.is_store ? 12'(AW'(ea_ff)) : 12'd0;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_exec_address = o_exec_ff;
   assign rsp_next_address = o_next_ff;
   assign rsp_fault        = o_fault_ff;
   assign rsp_reg_written  = o_rw_ff;
   assign rsp_reg_index    = o_idx_ff;
   assign rsp_reg_value    = o_val_ff;
   assign rsp_mem_written  = o_mw_ff;
   assign rsp_mem_address  = o_maddr_ff;

endmodule

[rtl/core/mips_subset_instruction_executor_core.sv]
// Top level of the MIPS integer subset instruction executor.
// Usage:
//   req_ channel: one transaction carries one 32-bit instruction word fetched at
//   the current program counter. rsp_ channel: one transaction per instruction,
//   giving the executed address, the next fetch address, a fault flag and a trace
//   of the register or memory write. csr_ channel: writes the start address,
//   loaded into the program counter at reset; write it only while idle.
// Operation:
//   The front part decodes the word and places it in a two-entry queue. The back
//   part reads the register file and memory banks into registers when it takes
//   an item, then writes back once the result register is free. It takes no new
//   instruction before that writeback, so the read and writeback loop through the
//   register file and memory sets the rate. The result is registered at writeback.
// Reset:
//   Reset clears the start address, sets the program counter to it and zeroes the
//   registers. The data memory is then cleared row by row, MEM_BYTES/4 rows of
//   four bytes, one row per cycle, during which no instruction is executed.
// Stall:
//   The result register holds its transaction while rsp_ready is low; the queue
//   keeps accepting until it is full.
module mips_subset_instruction_executor_core #(
   parameter int MEM_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_start_address,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_exec_address,
   output logic [31:0] rsp_next_address,
   output logic        rsp_fault,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [11:0] rsp_mem_address
);

   logic [31:0] start_ff;
   logic        dec_valid, dec_ready;
   msie_pkg::decoded_type dec_item;

   assign csr_ready = 1'b1;

   // The start address register returns to zero at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 32'd0;
      end else if (csr_valid) begin
         start_ff <= csr_start_address;
      end
   end

   msie_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instr_word (req_instr_word),
      .dec_valid      (dec_valid),
      .dec_ready      (dec_ready),
      .dec_item       (dec_item)
   );

   msie_execute #(.MEM_BYTES(MEM_BYTES)) u_execute (
      .clock            (clock),
      .reset            (reset),
      .start_address    (start_ff),
      .dec_valid        (dec_valid),
      .dec_ready        (dec_ready),
      .dec_item         (dec_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_exec_address (rsp_exec_address),
      .rsp_next_address (rsp_next_address),
      .rsp_fault        (rsp_fault),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_mem_written  (rsp_mem_written),
      .rsp_mem_address  (rsp_mem_address)
   );

endmodule
